>>> sv/clif_pkg.sv
`default_nettype none
package clif_pkg;

  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = 3;
  localparam int VOLT_W = 16;
  localparam int COND_W = 16;
  localparam int RATE_W = 16;
  localparam int MUL_A_W = 19;
  localparam int MUL_B_W = 18;
  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam int DRV_W = 36;
  localparam int DRV_SPLIT = 18;
  localparam int ACC_W = 52;
  localparam int DV_SHIFT = 28;
  localparam int LEAK_SHIFT = 12;
  localparam int STEP_W = 4;

  localparam logic [REG_IDX_W-1:0] REG_REST      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_AFTER     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_EX_REV    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_IN_REV    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MRATE     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ERATE     = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_IRATE     = 3'd7;

  localparam logic [15:0] REG_RESET [NUM_REGS] = '{
    16'hB600, 16'hCA00, 16'hC400, 16'h0000,
    16'hA800, 16'd410, 16'd1638, 16'd1638
  };

  localparam logic [0:0] OP_TICK  = 1'b0;
  localparam logic [0:0] OP_SPIKE = 1'b1;

  typedef enum logic [1:0] {A_GEX, A_GIN, A_DLO, A_DHI} a_sel_t;
  typedef enum logic [2:0] {B_EEX, B_EIN, B_MRATE, B_ERATE, B_IRATE} b_sel_t;
  typedef enum logic [2:0] {ACC_HOLD, ACC_LEAK, ACC_ADD, ACC_ADD_HI, ACC_DRIVE} acc_op_t;

  typedef struct packed {
    a_sel_t              a_sel;
    b_sel_t              b_sel;
    acc_op_t             acc_op;
    logic                wr_v;
    logic                wr_gex;
    logic                wr_gin;
    logic                wr_syn;
    logic                jmp_spike;
    logic [STEP_W-1:0]   target;
    logic                last;
  } ucode_t;

  localparam logic [STEP_W-1:0] STEP_SPIKE = 4'd8;

  localparam ucode_t UC_NOP = '{
    a_sel: A_GEX, b_sel: B_EEX, acc_op: ACC_HOLD, wr_v: 1'b0, wr_gex: 1'b0,
    wr_gin: 1'b0, wr_syn: 1'b0, jmp_spike: 1'b0, target: '0, last: 1'b0
  };

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = UC_NOP;
    case (step)
      4'd0: begin
        w.a_sel = A_GEX; w.b_sel = B_EEX; w.acc_op = ACC_LEAK;
        w.jmp_spike = 1'b1; w.target = STEP_SPIKE;
      end
      4'd1: begin
        w.a_sel = A_GIN; w.b_sel = B_EIN; w.acc_op = ACC_ADD;
      end
      4'd2: begin
        w.acc_op = ACC_DRIVE;
      end
      4'd3: begin
        w.a_sel = A_DLO; w.b_sel = B_MRATE;
      end
      4'd4: begin
        w.a_sel = A_DHI; w.b_sel = B_MRATE; w.acc_op = ACC_ADD;
      end
      4'd5: begin
        w.a_sel = A_GEX; w.b_sel = B_ERATE; w.acc_op = ACC_ADD_HI;
      end
      4'd6: begin
        w.a_sel = A_GIN; w.b_sel = B_IRATE; w.wr_v = 1'b1; w.wr_gex = 1'b1;
      end
      4'd7: begin
        w.wr_gin = 1'b1; w.last = 1'b1;
      end
      STEP_SPIKE: begin
        w.wr_syn = 1'b1; w.last = 1'b1;
      end
      default: w = UC_NOP;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> sv/clif_datapath.sv
`default_nettype none
module clif_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire clif_pkg::ucode_t               uc,
  input  wire logic                           en,
  input  wire logic                           cfg_we,
  input  wire logic [clif_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                    cfg_data,
  input  wire logic                           syn_inh,
  input  wire logic [clif_pkg::COND_W-1:0]    syn_weight,
  output logic signed [clif_pkg::VOLT_W-1:0]  voltage,
  output logic                                fired
);
  import clif_pkg::*;

  localparam int DV_W = ACC_W - DV_SHIFT;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (DV_SHIFT - 1);

  logic [15:0]                cfg_reg [NUM_REGS];
  logic [COND_W-1:0]          gex;
  logic [COND_W-1:0]          gin;
  logic signed [PROD_W-1:0]   preg;
  logic signed [ACC_W-1:0]    acc;
  logic signed [DRV_W-1:0]    drv;

  logic signed [VOLT_W:0]     diff_rest, diff_ex, diff_in;
  logic signed [MUL_A_W-1:0]  a_val;
  logic signed [MUL_B_W-1:0]  b_val;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    preg_ext, leak, acc_sum, rnd;
  logic signed [DV_W-1:0]     dv;
  logic signed [DV_W:0]       nv;
  logic signed [VOLT_W-1:0]   sat_v, new_v;
  logic                       fire;
  logic [32:0]                round_sum;
  logic [COND_W:0]            dec, syn_sum, syn_base;
  logic [COND_W-1:0]          gex_next, gin_next, syn_sat;

  always_comb begin
    diff_rest = {cfg_reg[REG_REST][15], cfg_reg[REG_REST]} - {voltage[VOLT_W-1], voltage};
    diff_ex = {cfg_reg[REG_EX_REV][15], cfg_reg[REG_EX_REV]} - {voltage[VOLT_W-1], voltage};
    diff_in = {cfg_reg[REG_IN_REV][15], cfg_reg[REG_IN_REV]} - {voltage[VOLT_W-1], voltage};

    case (uc.a_sel)
      A_GEX:   a_val = {3'b000, gex};
      A_GIN:   a_val = {3'b000, gin};
      A_DLO:   a_val = {1'b0, drv[DRV_SPLIT-1:0]};
      A_DHI:   a_val = {drv[DRV_W-1], drv[DRV_W-1:DRV_SPLIT]};
      default: a_val = '0;
    endcase
    case (uc.b_sel)
      B_EEX:   b_val = {diff_ex[VOLT_W], diff_ex};
      B_EIN:   b_val = {diff_in[VOLT_W], diff_in};
      B_MRATE: b_val = {2'b00, cfg_reg[REG_MRATE]};
      B_ERATE: b_val = {2'b00, cfg_reg[REG_ERATE]};
      B_IRATE: b_val = {2'b00, cfg_reg[REG_IRATE]};
      default: b_val = '0;
    endcase
    prod = a_val * b_val;

    preg_ext = {{(ACC_W-PROD_W){preg[PROD_W-1]}}, preg};
    leak = {{(ACC_W-VOLT_W-1-LEAK_SHIFT){diff_rest[VOLT_W]}}, diff_rest, {LEAK_SHIFT{1'b0}}};
    acc_sum = acc + preg_ext;

    // round to nearest, ties up, then floor shift
    rnd = acc + ROUND_HALF;
    dv = rnd[ACC_W-1:DV_SHIFT];
    nv = {{(DV_W+1-VOLT_W){voltage[VOLT_W-1]}}, voltage} + {dv[DV_W-1], dv};
    if (nv[DV_W:VOLT_W-1] == '0 || nv[DV_W:VOLT_W-1] == '1) begin
      sat_v = nv[VOLT_W-1:0];
    end else begin
      sat_v = nv[DV_W] ? {1'b1, {(VOLT_W-1){1'b0}}} : {1'b0, {(VOLT_W-1){1'b1}}};
    end
    fire = sat_v >= $signed(cfg_reg[REG_THRESHOLD]);
    new_v = fire ? $signed(cfg_reg[REG_AFTER]) : sat_v;

    round_sum = {1'b0, preg[31:0]} + 33'd32768;
    dec = round_sum[32:16];
    gex_next = (dec >= {1'b0, gex}) ? '0 : gex - dec[COND_W-1:0];
    gin_next = (dec >= {1'b0, gin}) ? '0 : gin - dec[COND_W-1:0];

    syn_base = syn_inh ? {1'b0, gin} : {1'b0, gex};
    syn_sum = syn_base + {1'b0, syn_weight};
    syn_sat = syn_sum[COND_W] ? '1 : syn_sum[COND_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_reg[i] <= REG_RESET[i];
      end
      voltage <= $signed(REG_RESET[REG_REST]);
      gex <= '0;
      gin <= '0;
      fired <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_reg[cfg_index] <= cfg_data;
      end
      if (en) begin
        if (uc.wr_v) begin
          voltage <= new_v;
          fired <= fire;
        end
        if (uc.wr_gex) gex <= gex_next;
        if (uc.wr_gin) gin <= gin_next;
        if (uc.wr_syn) begin
          if (syn_inh) gin <= syn_sat;
          else gex <= syn_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      preg <= prod;
      case (uc.acc_op)
        ACC_HOLD:   acc <= acc;
        ACC_LEAK:   acc <= leak;
        ACC_ADD:    acc <= acc_sum;
        ACC_ADD_HI: acc <= acc + {preg_ext[ACC_W-1-DRV_SPLIT:0], {DRV_SPLIT{1'b0}}};
        ACC_DRIVE: begin
          drv <= acc_sum[DRV_W-1:0];
          acc <= '0;
        end
        default:    acc <= acc;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/conductance_lif_neuron_core.sv
// Conductance-based leaky integrate-and-fire neuron. Each input transaction is
// a tick (forward Euler step of voltage and both conductances, threshold test
// and reset) or a spike arrival (adds the weight to one conductance) and
// yields exactly one output transaction with the voltage and the fired flag.
// A microcoded step sequencer drives one shared 19x18 multiplier: a tick runs
// eight steps and a spike arrival two. The next transaction is accepted the
// cycle after the result is loaded, even while it waits on m_axis_tready.
// Configuration writes take effect at once and are meant for idle periods.
`default_nettype none
module conductance_lif_neuron_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [15:0]                    s_axis_tdata,  // [15:0] synaptic_weight
  input  wire logic [1:0]                     s_axis_tuser,  // [0] operation, [1] source_inhibitory
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [15:0]                         m_axis_tdata,  // [15:0] membrane_voltage
  output logic [0:0]                          m_axis_tuser,  // [0] fired
  input  wire logic                           cfg_we,
  input  wire logic [clif_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                    cfg_data
);
  import clif_pkg::*;

  logic                      busy;
  logic [STEP_W-1:0]         step;
  logic [0:0]                op;
  logic                      inh;
  logic [COND_W-1:0]         weight;
  ucode_t                    uc;
  logic                      stall;
  logic                      adv;
  logic signed [VOLT_W-1:0]  voltage;
  logic                      fired;

  assign uc = ucode_rom(step);
  assign stall = uc.last && m_axis_tvalid && !m_axis_tready;
  assign adv = busy && !stall;
  assign s_axis_tready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (s_axis_tvalid && !busy) begin
        busy <= 1'b1;
        step <= '0;
        op <= s_axis_tuser[0:0];
        inh <= s_axis_tuser[1];
        weight <= s_axis_tdata;
      end else if (adv) begin
        if (uc.last) begin
          busy <= 1'b0;
          m_axis_tvalid <= 1'b1;
          m_axis_tdata <= voltage;
          m_axis_tuser[0] <= fired && (op == OP_TICK);
        end else if (uc.jmp_spike && op == OP_SPIKE) begin
          step <= uc.target;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  clif_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .uc         (uc),
    .en         (adv),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .syn_inh    (inh),
    .syn_weight (weight),
    .voltage    (voltage),
    .fired      (fired)
  );

endmodule
`default_nettype wire

>>> sv/clif_checker.sv
`default_nettype none
module clif_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transaction");

  a_spike_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] && !m_axis_tvalid
    |-> ##3 (m_axis_tvalid && !m_axis_tuser[0]))
    else $error("spike arrival result missing or marked fired");

  a_tick_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] && !m_axis_tvalid
    |-> ##9 m_axis_tvalid)
    else $error("tick result missing");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready
    |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind conductance_lif_neuron_core clif_checker u_clif_checker (.*);
`default_nettype wire
